/* hw/rtl/aad_pkg.sv */
// aad_pkg: shared widths, types, constants and the CORDIC arctangent table
// for the aerodynamic-angle direction cosine matrix block.
// No dependencies; every other file of the block imports it.
package aad_pkg;

  localparam int ACT_W            = 2;
  localparam int ANG_W            = 16;
  localparam int ENT_W            = 16;
  localparam int XY_W             = 34;
  localparam int Z_W              = 34;
  localparam int ATAN_ENTRIES     = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANG_SHIFT        = 17;  // Q2.13 -> Q30

  typedef logic signed [XY_W-1:0]  xy_t;
  typedef logic signed [Z_W-1:0]   z_t;
  typedef logic signed [ENT_W-1:0] ent_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_WIND_FROM_BODY = 2'd0,
    ACT_BODY_FROM_WIND = 2'd1,
    ACT_STAB_FROM_BODY = 2'd2
  } act_t;

  localparam z_t   Q30_HALF_PI  = 34'sd1686629713;
  localparam z_t   Q30_PI       = 34'sd3373259426;
  localparam xy_t  Q30_INV_GAIN = 34'sd652032874;
  localparam ent_t Q14_ONE      = 16'sd16384;

  // One angle's rotator state.
  typedef struct packed {
    xy_t  x;
    xy_t  y;
    z_t   z;
    logic flip;
  } rot_t;

  // Word travelling down the CORDIC pipe.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    rot_t             a;
    rot_t             b;
  } cord_t;

  typedef struct packed {
    ent_t row1_col1;
    ent_t row1_col2;
    ent_t row1_col3;
    ent_t row2_col1;
    ent_t row2_col2;
    ent_t row2_col3;
    ent_t row3_col1;
    ent_t row3_col2;
    ent_t row3_col3;
  } dcm_t;

  // floor(atan(2^-i) * 2^30)
  function automatic z_t atan_q30(input int idx);
    case (idx)
      0:       atan_q30 = 34'sh3243F6A8;
      1:       atan_q30 = 34'sh1DAC6705;
      2:       atan_q30 = 34'sh0FADBAFC;
      3:       atan_q30 = 34'sh07F56EA6;
      4:       atan_q30 = 34'sh03FEAB76;
      5:       atan_q30 = 34'sh01FFD55B;
      6:       atan_q30 = 34'sh00FFFAAA;
      7:       atan_q30 = 34'sh007FFF55;
      8:       atan_q30 = 34'sh003FFFEA;
      9:       atan_q30 = 34'sh001FFFFD;
      10:      atan_q30 = 34'sh000FFFFF;
      11:      atan_q30 = 34'sh0007FFFF;
      12:      atan_q30 = 34'sh0003FFFF;
      13:      atan_q30 = 34'sh0001FFFF;
      14:      atan_q30 = 34'sh0000FFFF;
      15:      atan_q30 = 34'sh00007FFF;
      16:      atan_q30 = 34'sh00003FFF;
      17:      atan_q30 = 34'sh00001FFF;
      18:      atan_q30 = 34'sh00000FFF;
      19:      atan_q30 = 34'sh000007FF;
      20:      atan_q30 = 34'sh000003FF;
      21:      atan_q30 = 34'sh000001FF;
      22:      atan_q30 = 34'sh000000FF;
      23:      atan_q30 = 34'sh0000007F;
      default: atan_q30 = '0;
    endcase
  endfunction

endpackage

/* hw/rtl/aad_if.sv */
// aad_if: valid/ready channel interfaces for the angle input words and the
// matrix result words. Depends on aad_pkg for widths and types.
interface aad_in_if import aad_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  ang_t             alpha;
  ang_t             beta;

  modport source (output valid, action, alpha, beta, input ready);
  modport sink   (input valid, action, alpha, beta, output ready);
endinterface

interface aad_out_if import aad_pkg::*; ();
  logic valid;
  logic ready;
  ent_t row1_col1;
  ent_t row1_col2;
  ent_t row1_col3;
  ent_t row2_col1;
  ent_t row2_col2;
  ent_t row2_col3;
  ent_t row3_col1;
  ent_t row3_col2;
  ent_t row3_col3;

  modport source (output valid, row1_col1, row1_col2, row1_col3, row2_col1, row2_col2,
                  row2_col3, row3_col1, row3_col2, row3_col3, input ready);
  modport sink   (input valid, row1_col1, row1_col2, row1_col3, row2_col1, row2_col2,
                  row2_col3, row3_col1, row3_col2, row3_col3, output ready);
endinterface

/* hw/rtl/aad_fold.sv */
// aad_fold: entry stage. Scales both angles to Q30, folds them into
// [-pi/2, pi/2] and seeds the rotators. Depends on aad_pkg.
module aad_fold import aad_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [ACT_W-1:0] in_action,
  input  ang_t             in_alpha,
  input  ang_t             in_beta,
  output logic             up_take,
  input  logic             dn_take,
  output logic             out_vld,
  output cord_t            out_data
);

  logic  vld_r;
  cord_t data_r;
  cord_t data_nxt;

  function automatic rot_t seed(input ang_t ang);
    z_t   z;
    rot_t r;
    z = {ang[ANG_W-1], ang, {ANG_SHIFT{1'b0}}};
    r.x = Q30_INV_GAIN;
    r.y = '0;
    if (z > Q30_HALF_PI) begin
      r.z    = z - Q30_PI;
      r.flip = 1'b1;
    end else if (z < -Q30_HALF_PI) begin
      r.z    = z + Q30_PI;
      r.flip = 1'b1;
    end else begin
      r.z    = z;
      r.flip = 1'b0;
    end
    return r;
  endfunction

  always_comb begin
    data_nxt.action = in_action;
    data_nxt.a      = seed(in_alpha);
    data_nxt.b      = seed(in_beta);
  end

  assign up_take  = ~vld_r | dn_take;
  assign out_vld  = vld_r;
  assign out_data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_take) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_take && in_vld) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* hw/rtl/aad_cordic_stage.sv */
// aad_cordic_stage: one registered rotation-mode CORDIC iteration applied to
// both angles at once. Depends on aad_pkg (types, arctangent table).
module aad_cordic_stage import aad_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_vld,
  input  cord_t in_data,
  output logic  up_take,
  input  logic  dn_take,
  output logic  out_vld,
  output cord_t out_data
);

  localparam z_t ATAN = atan_q30(STEP);

  logic  vld_r;
  cord_t data_r;
  cord_t data_nxt;

  function automatic rot_t rotate(input rot_t r);
    xy_t  dx;
    xy_t  dy;
    rot_t o;
    dx     = r.y >>> STEP;
    dy     = r.x >>> STEP;
    o.flip = r.flip;
    if (!r.z[Z_W-1]) begin
      o.x = r.x - dx;
      o.y = r.y + dy;
      o.z = r.z - ATAN;
    end else begin
      o.x = r.x + dx;
      o.y = r.y - dy;
      o.z = r.z + ATAN;
    end
    return o;
  endfunction

  always_comb begin
    data_nxt.action = in_data.action;
    data_nxt.a      = rotate(in_data.a);
    data_nxt.b      = rotate(in_data.b);
  end

  assign up_take  = ~vld_r | dn_take;
  assign out_vld  = vld_r;
  assign out_data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_take) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_take && in_vld) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* hw/rtl/aad_dcm_form.sv */
// aad_dcm_form: back end. Rounds the rotator outputs to Q1.14 sine/cosine,
// forms the four cross products, rounds them and selects the matrix.
// Three register stages; the last is the output register. Depends on aad_pkg.
module aad_dcm_form import aad_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_vld,
  input  cord_t in_data,
  output logic  up_take,
  input  logic  dn_take,
  output logic  out_vld,
  output dcm_t  out_data
);

  typedef logic signed [2*ENT_W-1:0] prod_t;

  // stage 1: rounded sine/cosine
  logic             vld1_r;
  logic [ACT_W-1:0] s1_act_r;
  ent_t             s1_sa_r, s1_ca_r, s1_sb_r, s1_cb_r;
  ent_t             sa_nxt, ca_nxt, sb_nxt, cb_nxt;
  // stage 2: products
  logic             vld2_r;
  logic [ACT_W-1:0] s2_act_r;
  ent_t             s2_sa_r, s2_ca_r, s2_sb_r, s2_cb_r;
  prod_t            s2_cc_r, s2_nsc_r, s2_cs_r, s2_nss_r;
  prod_t            cc_nxt, nsc_nxt, cs_nxt, nss_nxt;
  ent_t             nsb;
  // stage 3: output
  logic             vld3_r;
  dcm_t             dcm_r;
  dcm_t             dcm_nxt;
  ent_t             cc, nsc, cs, nss, nsa;
  logic             t1, t2, t3;

  function automatic ent_t sat_q14(input xy_t v);
    if (v > xy_t'(Q14_ONE)) begin
      sat_q14 = Q14_ONE;
    end else if (v < -xy_t'(Q14_ONE)) begin
      sat_q14 = -Q14_ONE;
    end else begin
      sat_q14 = ent_t'(v);
    end
  endfunction

  // Q30 -> Q1.14, half up, after undoing the half-turn fold
  function automatic ent_t rnd_q30(input xy_t v, input logic flip);
    xy_t f;
    f = flip ? -v : v;
    return sat_q14((f + xy_t'(32768)) >>> 16);
  endfunction

  function automatic ent_t rnd_prod(input prod_t p);
    return sat_q14((xy_t'(p) + xy_t'(8192)) >>> 14);
  endfunction

  assign t3      = ~vld3_r | dn_take;
  assign t2      = ~vld2_r | t3;
  assign t1      = ~vld1_r | t2;
  assign up_take = t1;

  assign ca_nxt = rnd_q30(in_data.a.x, in_data.a.flip);
  assign sa_nxt = rnd_q30(in_data.a.y, in_data.a.flip);
  assign cb_nxt = rnd_q30(in_data.b.x, in_data.b.flip);
  assign sb_nxt = rnd_q30(in_data.b.y, in_data.b.flip);

  // the negated factor goes in before the multiply
  assign nsb     = -s1_sb_r;
  assign cc_nxt  = prod_t'(s1_cb_r) * prod_t'(s1_ca_r);
  assign nsc_nxt = prod_t'(nsb) * prod_t'(s1_ca_r);
  assign cs_nxt  = prod_t'(s1_cb_r) * prod_t'(s1_sa_r);
  assign nss_nxt = prod_t'(nsb) * prod_t'(s1_sa_r);

  assign cc  = rnd_prod(s2_cc_r);
  assign nsc = rnd_prod(s2_nsc_r);
  assign cs  = rnd_prod(s2_cs_r);
  assign nss = rnd_prod(s2_nss_r);
  assign nsa = -s2_sa_r;

  always_comb begin
    dcm_nxt = '0;
    unique case (s2_act_r)
      ACT_WIND_FROM_BODY: begin
        dcm_nxt.row1_col1 = cc;
        dcm_nxt.row1_col2 = s2_sb_r;
        dcm_nxt.row1_col3 = cs;
        dcm_nxt.row2_col1 = nsc;
        dcm_nxt.row2_col2 = s2_cb_r;
        dcm_nxt.row2_col3 = nss;
        dcm_nxt.row3_col1 = nsa;
        dcm_nxt.row3_col3 = s2_ca_r;
      end
      ACT_BODY_FROM_WIND: begin
        dcm_nxt.row1_col1 = cc;
        dcm_nxt.row1_col2 = nsc;
        dcm_nxt.row1_col3 = nsa;
        dcm_nxt.row2_col1 = s2_sb_r;
        dcm_nxt.row2_col2 = s2_cb_r;
        dcm_nxt.row3_col1 = cs;
        dcm_nxt.row3_col2 = nss;
        dcm_nxt.row3_col3 = s2_ca_r;
      end
      ACT_STAB_FROM_BODY: begin
        dcm_nxt.row1_col1 = s2_ca_r;
        dcm_nxt.row1_col3 = s2_sa_r;
        dcm_nxt.row2_col2 = Q14_ONE;
        dcm_nxt.row3_col1 = nsa;
        dcm_nxt.row3_col3 = s2_ca_r;
      end
      default: begin
        dcm_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      if (t1) begin
        vld1_r <= in_vld;
      end
      if (t2) begin
        vld2_r <= vld1_r;
      end
      if (t3) begin
        vld3_r <= vld2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (t1 && in_vld) begin
      s1_act_r <= in_data.action;
      s1_sa_r  <= sa_nxt;
      s1_ca_r  <= ca_nxt;
      s1_sb_r  <= sb_nxt;
      s1_cb_r  <= cb_nxt;
    end
    if (t2 && vld1_r) begin
      s2_act_r <= s1_act_r;
      s2_sa_r  <= s1_sa_r;
      s2_ca_r  <= s1_ca_r;
      s2_sb_r  <= s1_sb_r;
      s2_cb_r  <= s1_cb_r;
      s2_cc_r  <= cc_nxt;
      s2_nsc_r <= nsc_nxt;
      s2_cs_r  <= cs_nxt;
      s2_nss_r <= nss_nxt;
    end
    if (t3 && vld2_r) begin
      dcm_r <= dcm_nxt;
    end
  end

  assign out_vld  = vld3_r;
  assign out_data = dcm_r;

endmodule

/* hw/rtl/aero_angle_dcm.sv */
// aero_angle_dcm: top level of the aerodynamic-angle direction cosine matrix.
// Depends on aad_pkg, aad_if, aad_fold, aad_cordic_stage and aad_dcm_form.
//
// Each input word carries angle of attack and sideslip (Q2.13 radians, the
// full 16-bit range up to +-4 rad is folded correctly) and an action code;
// each output word is one 3x3 matrix in Q1.14, row-major, every entry
// saturated to +-1.0. Action 0 is wind-from-body Rz(beta)*Ry(-alpha),
// action 1 its transpose (body-from-wind), action 2 stability-from-body
// Ry(-alpha) with beta ignored; the unused code gives an all-zero matrix.
// Every input word yields exactly one output word, in order. The block is a
// fully pipelined datapath: one word per clock sustained while the output
// is ready. It has one fold stage, one register per CORDIC iteration and
// three back-end stages (sin/cos rounding, 16x16 products, product rounding
// plus matrix select). Both angles rotate side by side in the same stages.
// Every stage has its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles are squeezed out and a stalled output only
// backs up as far as the pipe is full; input ready stays high while any
// stage has room. The last stage is the output register. Nothing is stored
// between words; no configuration.
module aero_angle_dcm import aad_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  aad_in_if.sink    in_ch,
  aad_out_if.source out_ch
);

  // Iterations beyond the arctangent table are not run.
  localparam int NSTG = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  // Pipe taps: index k feeds CORDIC stage k; index NSTG feeds the back end.
  cord_t cord_d [0:NSTG];
  logic  vld_d  [0:NSTG];
  logic  take_d [0:NSTG];
  dcm_t  dcm;

  aad_fold u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_ch.valid),
    .in_action(in_ch.action),
    .in_alpha (in_ch.alpha),
    .in_beta  (in_ch.beta),
    .up_take  (in_ch.ready),
    .dn_take  (take_d[0]),
    .out_vld  (vld_d[0]),
    .out_data (cord_d[0])
  );

  // One register stage per micro-rotation; the shift and arctangent constant
  // are fixed per stage.
  for (genvar k = 0; k < NSTG; k++) begin : g_cordic
    aad_cordic_stage #(
      .STEP(k)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (vld_d[k]),
      .in_data (cord_d[k]),
      .up_take (take_d[k]),
      .dn_take (take_d[k+1]),
      .out_vld (vld_d[k+1]),
      .out_data(cord_d[k+1])
    );
  end

  aad_dcm_form u_form (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld_d[NSTG]),
    .in_data (cord_d[NSTG]),
    .up_take (take_d[NSTG]),
    .dn_take (out_ch.ready),
    .out_vld (out_ch.valid),
    .out_data(dcm)
  );

  assign out_ch.row1_col1 = dcm.row1_col1;
  assign out_ch.row1_col2 = dcm.row1_col2;
  assign out_ch.row1_col3 = dcm.row1_col3;
  assign out_ch.row2_col1 = dcm.row2_col1;
  assign out_ch.row2_col2 = dcm.row2_col2;
  assign out_ch.row2_col3 = dcm.row2_col3;
  assign out_ch.row3_col1 = dcm.row3_col1;
  assign out_ch.row3_col2 = dcm.row3_col2;
  assign out_ch.row3_col3 = dcm.row3_col3;

endmodule

/* hw/rtl/aad_checker.sv */
// aad_checker: port-level assertions for aero_angle_dcm, attached by bind.
// Depends on aad_pkg for the entry type and the Q1.14 unit constant.
module aad_checker import aad_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input ent_t row1_col1,
  input ent_t row1_col2,
  input ent_t row1_col3,
  input ent_t row2_col1,
  input ent_t row2_col2,
  input ent_t row2_col3,
  input ent_t row3_col1,
  input ent_t row3_col2,
  input ent_t row3_col3
);

  logic [7:0] inflight_r;
  logic [7:0] inflight_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_acc && !out_acc) begin
      inflight_nxt = inflight_r + 8'd1;
    end else if (out_acc && !in_acc) begin
      inflight_nxt = inflight_r - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  function automatic logic in_rng(input ent_t v);
    return (v >= -Q14_ONE) && (v <= Q14_ONE);
  endfunction

  // reset empties the pipe
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  // a held word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // no output word without an input word still owed
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (inflight_r != 8'd0))
    else $error("output word with no input word in flight");

  // every entry saturated to +-1.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (in_rng(row1_col1) && in_rng(row1_col2) && in_rng(row1_col3) &&
                   in_rng(row2_col1) && in_rng(row2_col2) && in_rng(row2_col3) &&
                   in_rng(row3_col1) && in_rng(row3_col2) && in_rng(row3_col3)))
    else $error("matrix entry beyond +-1.0");

endmodule

bind aero_angle_dcm aad_checker u_aad_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .row1_col1(out_ch.row1_col1),
  .row1_col2(out_ch.row1_col2),
  .row1_col3(out_ch.row1_col3),
  .row2_col1(out_ch.row2_col1),
  .row2_col2(out_ch.row2_col2),
  .row2_col3(out_ch.row2_col3),
  .row3_col1(out_ch.row3_col1),
  .row3_col2(out_ch.row3_col2),
  .row3_col3(out_ch.row3_col3)
);

/* verif/aero_angle_dcm_checker.sv */
`timescale 1ns / 1ps
// aero_angle_dcm_checker: watches the angle and matrix channels of aero_angle_dcm,
// predicts each matrix word and compares it field by field, in order.
// Depends on aad_pkg and the channel interfaces of aad_if.
module aero_angle_dcm_checker import aad_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  aad_in_if    in_mon,
  aad_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  localparam int ROTATIONS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint GAIN_INV    = 64'sd652032874;
  localparam longint UNIT_Q14    = 64'sd16384;

  // floor(atan(2^-i) * 2^30)
  localparam longint ARCTAN_Q30 [24] = '{
    64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6,
    64'sh03FEAB76, 64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55,
    64'sh003FFFEA, 64'sh001FFFFD, 64'sh000FFFFF, 64'sh0007FFFF,
    64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF, 64'sh00007FFF,
    64'sh00003FFF, 64'sh00001FFF, 64'sh00000FFF, 64'sh000007FF,
    64'sh000003FF, 64'sh000001FF, 64'sh000000FF, 64'sh0000007F
  };

  typedef struct {
    logic [ACT_W-1:0] action;
    ang_t             alpha;
    ang_t             beta;
    dcm_t             m;
  } dcm_expect_t;

  dcm_expect_t dcm_q[$];
  int          errs = 0;
  string       field_name [9] = '{"row1_col1", "row1_col2", "row1_col3",
                                  "row2_col1", "row2_col2", "row2_col3",
                                  "row3_col1", "row3_col2", "row3_col3"};

  assign fail_count = errs;
  assign pending    = dcm_q.size();

  function automatic longint clamp_unit(input longint v);
    if (v > UNIT_Q14) return UNIT_Q14;
    if (v < -UNIT_Q14) return -UNIT_Q14;
    return v;
  endfunction

  // Fold to +-pi/2, rotate, then round both to Q1.14.
  function automatic void sincos_q14(input ang_t ang, output longint s, output longint c);
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit     flip;
    z    = longint'(ang) * 131072;
    x    = GAIN_INV;
    y    = 0;
    flip = 1'b0;
    if (z > HALF_PI_Q30) begin
      z    = z - PI_Q30;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z    = z + PI_Q30;
      flip = 1'b1;
    end
    for (int i = 0; i < ROTATIONS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_Q30[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_Q30[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp_unit((x + 32768) >>> 16);
    s = clamp_unit((y + 32768) >>> 16);
  endfunction

  function automatic longint mul_q14(input longint a, input longint b);
    return clamp_unit((a * b + 8192) >>> 14);
  endfunction

  function automatic dcm_t predict_dcm(input logic [ACT_W-1:0] act, input ang_t alpha,
                                       input ang_t beta);
    dcm_t   m;
    longint sa;
    longint ca;
    longint sb;
    longint cb;
    sincos_q14(alpha, sa, ca);
    sincos_q14(beta, sb, cb);
    m = '0;
    case (act)
      ACT_WIND_FROM_BODY: begin
        m.row1_col1 = ent_t'(mul_q14(cb, ca));
        m.row1_col2 = ent_t'(sb);
        m.row1_col3 = ent_t'(mul_q14(cb, sa));
        m.row2_col1 = ent_t'(mul_q14(-sb, ca));
        m.row2_col2 = ent_t'(cb);
        m.row2_col3 = ent_t'(mul_q14(-sb, sa));
        m.row3_col1 = ent_t'(-sa);
        m.row3_col3 = ent_t'(ca);
      end
      ACT_BODY_FROM_WIND: begin
        m.row1_col1 = ent_t'(mul_q14(ca, cb));
        m.row1_col2 = ent_t'(mul_q14(ca, -sb));
        m.row1_col3 = ent_t'(-sa);
        m.row2_col1 = ent_t'(sb);
        m.row2_col2 = ent_t'(cb);
        m.row3_col1 = ent_t'(mul_q14(sa, cb));
        m.row3_col2 = ent_t'(mul_q14(sa, -sb));
        m.row3_col3 = ent_t'(ca);
      end
      ACT_STAB_FROM_BODY: begin
        m.row1_col1 = ent_t'(ca);
        m.row1_col3 = ent_t'(sa);
        m.row2_col2 = Q14_ONE;
        m.row3_col1 = ent_t'(-sa);
        m.row3_col3 = ent_t'(ca);
      end
      default: m = '0;  // reserved code: all zero
    endcase
    return m;
  endfunction

  always @(posedge clk) begin
    dcm_expect_t           want;
    dcm_t                  got;
    logic [9*ENT_W-1:0]    want_bits;
    logic [9*ENT_W-1:0]    got_bits;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        want.action = in_mon.action;
        want.alpha  = in_mon.alpha;
        want.beta   = in_mon.beta;
        want.m      = predict_dcm(in_mon.action, in_mon.alpha, in_mon.beta);
        dcm_q.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.row1_col1, out_mon.row1_col2, out_mon.row1_col3,
               out_mon.row2_col1, out_mon.row2_col2, out_mon.row2_col3,
               out_mon.row3_col1, out_mon.row3_col2, out_mon.row3_col3};
        if (dcm_q.size() == 0) begin
          if (errs < 10)
            $display("%0t: matrix word with none expected", $time);
          errs++;
        end else begin
          want      = dcm_q.pop_front();
          want_bits = want.m;
          got_bits  = got;
          for (int k = 0; k < 9; k++) begin
            if (got_bits[(8-k)*ENT_W +: ENT_W] !== want_bits[(8-k)*ENT_W +: ENT_W]) begin
              if (errs < 10)
                $display("%0t: %s mismatch (action %0d alpha %0d beta %0d): exp %0d got %0d",
                         $time, field_name[k], want.action, want.alpha, want.beta,
                         $signed(want_bits[(8-k)*ENT_W +: ENT_W]),
                         $signed(got_bits[(8-k)*ENT_W +: ENT_W]));
              errs++;
            end
          end
        end
      end
    end
  end

endmodule

/* verif/aero_angle_dcm_tb.sv */
`timescale 1ns / 1ps
// aero_angle_dcm_tb: stimulus and verdict for aero_angle_dcm.
// Depends on aad_pkg, aad_if, the block itself and aero_angle_dcm_checker.
module aero_angle_dcm_tb;
  import aad_pkg::*;

  localparam int STEPS   = CORDIC_STEPS_DEF;
  // Pipe depth from the block's head comment: fold + one stage per rotation + 3.
  localparam int LATENCY = ((STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS) + 4;
  localparam int RANDOM_WORDS = 1500;
  localparam logic [ACT_W-1:0] ACT_RESERVED = 2'd3;  // unused code, gives a zero matrix

  // Q2.13 landmarks: pi/2 rounds to 12868, which sits just above the fold
  // threshold; 12867 sits just below it. pi rounds to 25736.
  localparam int HALF_PI_Q13 = 12868;
  localparam int PI_Q13      = 25736;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   words_sent;

  aad_in_if  in_ch ();
  aad_out_if out_ch ();

  aero_angle_dcm #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  aero_angle_dcm_checker #(.CORDIC_STEPS(STEPS)) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Present one word at the falling edge and hold it until the block takes
  // it. Valid is left high on return so back-to-back words need no toggle.
  task automatic send_word(input logic [ACT_W-1:0] act, input int alpha, input int beta);
    in_ch.valid  = 1'b1;
    in_ch.action = act;
    in_ch.alpha  = ang_t'(alpha);
    in_ch.beta   = ang_t'(beta);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // Drop valid and wait until every predicted matrix has come back.
  task automatic drain_pipe();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Angles weighted toward the fold boundaries, +-pi and zero, with plenty of
  // the raw 16-bit range so every bit of the field toggles.
  function automatic int pick_angle();
    int mode;
    int mag;
    mode = $urandom_range(0, 5);
    case (mode)
      0, 1: return int'(ang_t'($urandom));
      2: return int'($urandom_range(0, 2 * PI_Q13)) - PI_Q13;
      3: mag = HALF_PI_Q13 + int'($urandom_range(0, 8)) - 4;
      4: mag = PI_Q13 + int'($urandom_range(0, 8)) - 4;
      default: mag = int'($urandom_range(0, 64)) - 32;
    endcase
    return $urandom_range(0, 1) ? mag : -mag;
  endfunction

  // Result side: ready follows a pattern picked at random and held for a random
  // run -- always ready, coin flip, mostly stalled, or a fixed duty cycle.
  int ready_mode = 0;
  int ready_left = 0;
  int ready_tick = 0;
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(20, 200);
    end
    ready_left--;
    ready_tick++;
    case (ready_mode)
      0:       out_ch.ready = 1'b1;
      1:       out_ch.ready = ($urandom_range(0, 1) == 1);
      2:       out_ch.ready = ($urandom_range(0, 3) == 0);
      default: out_ch.ready = ((ready_tick % 7) < 3);
    endcase
  end

  initial begin
    logic [ACT_W-1:0] codes [4];
    logic [ACT_W-1:0] act;
    int               burst;
    int               next_drain;
    codes = '{ACT_WIND_FROM_BODY, ACT_BODY_FROM_WIND, ACT_STAB_FROM_BODY, ACT_RESERVED};

    words_sent   = 0;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_WIND_FROM_BODY;
    in_ch.alpha  = '0;
    in_ch.beta   = '0;
    rst_n        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: every action code with zero angles, the extremes of the
    // 16-bit field, both sides of the pi/2 fold and +-pi.
    foreach (codes[c]) begin
      send_word(codes[c], 0, 0);
      send_word(codes[c], 32767, -32768);
      send_word(codes[c], -32768, 32767);
      send_word(codes[c], HALF_PI_Q13, -(HALF_PI_Q13 - 1));
      send_word(codes[c], -PI_Q13, PI_Q13);
    end
    drain_pipe();

    // Random: bursts of random length and random gaps, with a full drain
    // now and then so the pipe also restarts from empty.
    next_drain = words_sent + 400;
    while (words_sent < RANDOM_WORDS + 20) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        case ($urandom_range(0, 15))
          0:       act = ACT_RESERVED;
          1, 2, 3, 4, 5: act = ACT_WIND_FROM_BODY;
          6, 7, 8, 9, 10: act = ACT_BODY_FROM_WIND;
          default: act = ACT_STAB_FROM_BODY;
        endcase
        send_word(act, pick_angle(), pick_angle());
      end
      if (words_sent >= next_drain) begin
        drain_pipe();
        next_drain = words_sent + 400;
      end else if ($urandom_range(0, 3) != 0) begin
        in_ch.valid = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
    end

    drain_pipe();
    repeat (2 * LATENCY) @(negedge clk);
    if (fail_count == 0) begin
      $display("aero_angle_dcm_tb: PASS");
    end else begin
      $display("aero_angle_dcm_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("aero_angle_dcm_tb: FAIL");
    $finish;
  end

endmodule
